@@ src/hfl_pkg.sv @@
package hfl_pkg;

    localparam int HFL_MAX_ENTRIES_DEFAULT = 256;
    localparam int HFL_INDEX_W = 8;
    localparam int HFL_INDEX_SPAN = 256;
    localparam int HFL_LIMIT_W = 9;
    localparam int HFL_APB_DATA_W = 32;
    localparam int HFL_APB_ADDR_W = 3;

    localparam logic [HFL_LIMIT_W-1:0] HFL_MAX_HANDLES_RESET = 9'd256;
    localparam logic [HFL_APB_ADDR_W-1:0] HFL_ADDR_MAX_HANDLES = 3'd0;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_CHECK = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef struct packed {
        status_t                status;
        logic [HFL_INDEX_W-1:0] handle_index;
        logic                   valid_res;
    } res_t;

endpackage

@@ src/hfl_if.sv @@
interface hfl_req_if
    import hfl_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [1:0]             kind;
    logic [HFL_INDEX_W-1:0] index;

    modport source (output valid, output kind, output index, input ready);
    modport sink (input valid, input kind, input index, output ready);
endinterface

interface hfl_res_if
    import hfl_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic [HFL_INDEX_W-1:0] handle_index;
    logic                   valid_res;

    modport source (output valid, output status, output handle_index, output valid_res,
                    input ready);
    modport sink (input valid, input status, input handle_index, input valid_res,
                  output ready);
endinterface

@@ src/hfl_link_ram.sv @@
module hfl_link_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 9
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/hfl_out_stage.sv @@
module hfl_out_stage
    import hfl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  res_t      data,
    output logic      can_load,
    hfl_res_if.source res
);

    logic valid_reg;
    logic valid_next;
    res_t data_reg;

    assign can_load = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign res.valid        = valid_reg;
    assign res.status       = data_reg.status;
    assign res.handle_index = data_reg.handle_index;
    assign res.valid_res    = data_reg.valid_res;

endmodule

@@ src/handle_free_list_allocator_core.sv @@
// Handle allocator with a LIFO free list of released indices.
// Requests arrive on the req channel (kind, index) and each one yields exactly
// one item on the res channel (status, handle_index, valid_res), in order.
// An allocate pops the most recently freed index, or else hands out the next
// never-used index below the max_handles limit, or reports the table full.
// A free returns an allocated index to the list; a check reports whether an
// index is in range and allocated.
// The result item is registered at the edge that accepts the request.
// Throughput is one item per cycle, except that after an allocate served
// from the free list no request is taken in the next cycle, while the
// link RAM delivers the link of the new head.
// If the receiver stalls, one result item is held in the output register and
// the next request is taken only once that register can be refilled.
// Reset empties the free list, clears all allocated marks, restarts fresh
// allocation at index 0 and sets max_handles to 256. Link RAM contents need
// no clearing. max_handles is written over the APB port at address 0; the user
// must write it only while the block is idle, as the block does not enforce it.
module handle_free_list_allocator_core
    import hfl_pkg::*;
#(
    parameter int MAX_ENTRIES = HFL_MAX_ENTRIES_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [HFL_APB_ADDR_W-1:0] paddr,
    input  logic [HFL_APB_DATA_W-1:0] pwdata,
    output logic [HFL_APB_DATA_W-1:0] prdata,
    output logic                      pready,
    hfl_req_if.sink                   req,
    hfl_res_if.source                 res
);

    localparam int DEPTH  = (MAX_ENTRIES < HFL_INDEX_SPAN) ? MAX_ENTRIES : HFL_INDEX_SPAN;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int LINK_W = IDX_W + 1;

    logic [HFL_LIMIT_W-1:0] max_handles_reg;
    logic                   head_empty_reg;
    logic                   head_empty_next;
    logic [IDX_W-1:0]       head_idx_reg;
    logic [IDX_W-1:0]       head_idx_next;
    logic [LINK_W-1:0]      head_link_reg;
    logic [LINK_W-1:0]      head_link_next;
    logic                   link_pending_reg;
    logic                   link_pending_next;
    logic [CNT_W-1:0]       fresh_count_reg;
    logic [CNT_W-1:0]       fresh_count_next;
    logic [DEPTH-1:0]       mark_reg;
    logic [DEPTH-1:0]       mark_next;

    logic [HFL_LIMIT_W-1:0] lim;
    logic                   in_range;
    logic [IDX_W-1:0]       idx_n;
    logic                   mark_hit;
    logic                   accept;
    logic                   out_can_load;
    logic                   ram_we;
    logic [LINK_W-1:0]      ram_rdata;
    logic                   cfg_write;
    res_t                   result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == HFL_ADDR_MAX_HANDLES);
    assign prdata    = (paddr == HFL_ADDR_MAX_HANDLES) ?
                       HFL_APB_DATA_W'(max_handles_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_handles_reg <= HFL_MAX_HANDLES_RESET;
        end
        else if (cfg_write)
        begin
            max_handles_reg <= pwdata[HFL_LIMIT_W-1:0];
        end
    end

    assign lim      = (max_handles_reg > HFL_LIMIT_W'(DEPTH)) ?
                      HFL_LIMIT_W'(DEPTH) : max_handles_reg;
    assign in_range = HFL_LIMIT_W'(req.index) < lim;
    assign idx_n    = req.index[IDX_W-1:0];
    assign mark_hit = in_range && mark_reg[idx_n];

    assign req.ready = !link_pending_reg && out_can_load;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        head_empty_next   = head_empty_reg;
        head_idx_next     = head_idx_reg;
        head_link_next    = link_pending_reg ? ram_rdata : head_link_reg;
        link_pending_next = 1'b0;
        fresh_count_next  = fresh_count_reg;
        mark_next         = mark_reg;
        ram_we            = 1'b0;
        result.status       = ST_INVALID;
        result.handle_index = '0;
        result.valid_res    = 1'b0;

        case (req.kind)
            KIND_ALLOC:
            begin
                if (!head_empty_reg)
                begin
                    result.status       = ST_OK;
                    result.handle_index = HFL_INDEX_W'(head_idx_reg);
                    if (accept)
                    begin
                        head_empty_next        = head_link_reg[IDX_W];
                        head_idx_next          = head_link_reg[IDX_W-1:0];
                        link_pending_next      = 1'b1;
                        mark_next[head_idx_reg] = 1'b1;
                    end
                end
                else if (HFL_LIMIT_W'(fresh_count_reg) < lim)
                begin
                    result.status       = ST_OK;
                    result.handle_index = HFL_INDEX_W'(fresh_count_reg);
                    if (accept)
                    begin
                        fresh_count_next = fresh_count_reg + CNT_W'(1);
                        mark_next[fresh_count_reg[IDX_W-1:0]] = 1'b1;
                    end
                end
                else
                begin
                    result.status = ST_FULL;
                end
            end
            KIND_FREE:
            begin
                if (mark_hit)
                begin
                    result.status = ST_OK;
                    if (accept)
                    begin
                        mark_next[idx_n] = 1'b0;
                        ram_we           = 1'b1;
                        head_link_next   = {head_empty_reg, head_idx_reg};
                        head_empty_next  = 1'b0;
                        head_idx_next    = idx_n;
                    end
                end
            end
            KIND_CHECK:
            begin
                if (mark_hit)
                begin
                    result.status       = ST_OK;
                    result.handle_index = req.index;
                    result.valid_res    = 1'b1;
                end
            end
            default:
            begin
                result.status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_empty_reg   <= 1'b1;
            head_idx_reg     <= '0;
            head_link_reg    <= '0;
            link_pending_reg <= 1'b0;
            fresh_count_reg  <= '0;
            mark_reg         <= '0;
        end
        else
        begin
            head_empty_reg   <= head_empty_next;
            head_idx_reg     <= head_idx_next;
            head_link_reg    <= head_link_next;
            link_pending_reg <= link_pending_next;
            fresh_count_reg  <= fresh_count_next;
            mark_reg         <= mark_next;
        end
    end

    hfl_link_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (LINK_W)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_n),
        .wdata ({head_empty_reg, head_idx_reg}),
        .raddr (head_link_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    hfl_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .data     (result),
        .can_load (out_can_load),
        .res      (res)
    );

`ifndef SYNTHESIS
    a_pop_blocks_next: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.kind == KIND_ALLOC && !head_empty_reg) |=> !req.ready)
        else $error("Request taken while the head link was still being fetched.");

    a_head_not_marked: assert property (@(posedge clk) disable iff (!rst_n)
        !head_empty_reg |-> !mark_reg[head_idx_reg])
        else $error("Free list head is marked allocated.");

    a_fresh_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_count_reg <= CNT_W'(DEPTH))
        else $error("Fresh allocation count ran past the table depth.");

    a_accept_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res.valid)
        else $error("Accepted request produced no result item.");
`endif

endmodule

@@ verif/handle_free_list_allocator_core_test.sv @@
`timescale 1ns / 100ps

module handle_free_list_allocator_core_test
    import hfl_pkg::*;
();

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int PRESSURE_CYCLES = 400;
    localparam int SETTLE_CYCLES = 4;

    typedef struct {
        logic [1:0]             kind;
        logic [HFL_INDEX_W-1:0] index;
    } handle_req_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [HFL_APB_ADDR_W-1:0] paddr = '0;
    logic [HFL_APB_DATA_W-1:0] pwdata = '0;
    logic [HFL_APB_DATA_W-1:0] prdata;
    logic                      pready;

    hfl_req_if req_ch ();
    hfl_res_if res_ch ();

    handle_free_list_allocator_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .res     (res_ch)
    );

    // Shadow copy of the allocator state.
    logic [HFL_LIMIT_W-1:0] link_shadow [HFL_INDEX_SPAN];
    logic [HFL_LIMIT_W-1:0] head_shadow;
    logic [HFL_LIMIT_W-1:0] fresh_shadow;
    logic                   mark_shadow [HFL_INDEX_SPAN];
    logic [HFL_LIMIT_W-1:0] max_handles_shadow;

    handle_req_t request_backlog [$];
    res_t        expected_results [$];
    handle_req_t next_req;
    res_t        oldest_expected;

    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request_count = 0;
    int hold_seen_count;
    int hold_left;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic res_t predict_result(input logic [1:0] kind,
                                            input logic [HFL_INDEX_W-1:0] idx);
        res_t                   r;
        logic [HFL_LIMIT_W-1:0] lim;
        logic [HFL_LIMIT_W-1:0] taken;
        logic                   in_range;
        lim = (max_handles_shadow > HFL_LIMIT_W'(HFL_INDEX_SPAN)) ?
              HFL_LIMIT_W'(HFL_INDEX_SPAN) : max_handles_shadow;
        in_range = {1'b0, idx} < lim;
        r.status = ST_INVALID;
        r.handle_index = '0;
        r.valid_res = 1'b0;
        if (kind == KIND_ALLOC)
        begin
            if (head_shadow < HFL_LIMIT_W'(HFL_INDEX_SPAN))
            begin
                taken = head_shadow;
                head_shadow = link_shadow[taken[HFL_INDEX_W-1:0]];
                mark_shadow[taken[HFL_INDEX_W-1:0]] = 1'b1;
                r.status = ST_OK;
                r.handle_index = taken[HFL_INDEX_W-1:0];
            end
            else if (fresh_shadow < lim)
            begin
                taken = fresh_shadow;
                fresh_shadow = fresh_shadow + HFL_LIMIT_W'(1);
                mark_shadow[taken[HFL_INDEX_W-1:0]] = 1'b1;
                r.status = ST_OK;
                r.handle_index = taken[HFL_INDEX_W-1:0];
            end
            else
                r.status = ST_FULL;
        end
        else if (kind == KIND_FREE)
        begin
            if (in_range && mark_shadow[idx])
            begin
                mark_shadow[idx] = 1'b0;
                link_shadow[idx] = head_shadow;
                head_shadow = {1'b0, idx};
                r.status = ST_OK;
            end
        end
        else if (kind == KIND_CHECK)
        begin
            if (in_range && mark_shadow[idx])
            begin
                r.status = ST_OK;
                r.handle_index = idx;
                r.valid_res = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.kind <= '0;
            req_ch.index <= '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (request_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_req = request_backlog.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.kind <= next_req.kind;
                req_ch.index <= next_req.index;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            hold_seen_count <= 0;
            hold_left <= 0;
        end
        else if (hold_seen_count != hold_request_count)
        begin
            hold_seen_count <= hold_request_count;
            hold_left <= PRESSURE_CYCLES;
            res_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                expected_results.push_back(predict_result(req_ch.kind, req_ch.index));
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with no request outstanding");
                    error_count++;
                end
                else
                begin
                    oldest_expected = expected_results.pop_front();
                    if (res_ch.status !== oldest_expected.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               oldest_expected.status, res_ch.status);
                        error_count++;
                    end
                    if (res_ch.handle_index !== oldest_expected.handle_index)
                    begin
                        $error("handle_index: expected %0d, actual %0d",
                               oldest_expected.handle_index, res_ch.handle_index);
                        error_count++;
                    end
                    if (res_ch.valid_res !== oldest_expected.valid_res)
                    begin
                        $error("valid_res: expected %0d, actual %0d",
                               oldest_expected.valid_res, res_ch.valid_res);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic push_req(input logic [1:0] kind, input int idx);
        handle_req_t item;
        item.kind = kind;
        item.index = idx[HFL_INDEX_W-1:0];
        request_backlog.push_back(item);
    endtask

    task automatic settle();
        while (request_backlog.size() != 0 || req_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_handles(input int value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= HFL_ADDR_MAX_HANDLES;
        pwdata <= HFL_APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        max_handles_shadow = value[HFL_LIMIT_W-1:0];
    endtask

    task automatic run_phase(input int limit, input int send_pct, input int recv_pct,
                             input int count, input bit alloc_only, input bit pressure);
        int         lim_eff;
        int         bound;
        int         roll;
        int         idx;
        logic [1:0] kind;
        settle();
        write_max_handles(limit);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        lim_eff = (limit > HFL_INDEX_SPAN) ? HFL_INDEX_SPAN : limit;
        bound = lim_eff + lim_eff / 4 + 1;
        if (bound > HFL_INDEX_SPAN - 1)
            bound = HFL_INDEX_SPAN - 1;
        if (pressure)
            hold_request_count++;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (alloc_only || roll < 40)
                kind = KIND_ALLOC;
            else if (roll < 75)
                kind = KIND_FREE;
            else if (roll < 95)
                kind = KIND_CHECK;
            else
                kind = KIND_UNUSED;
            if ($urandom_range(0, 4) == 0)
                idx = $urandom_range(0, HFL_INDEX_SPAN - 1);
            else
                idx = $urandom_range(0, bound);
            push_req(kind, idx);
        end
    endtask

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.kind = '0;
        req_ch.index = '0;
        res_ch.ready = 1'b0;
        max_handles_shadow = HFL_MAX_HANDLES_RESET;
        head_shadow = HFL_LIMIT_W'(HFL_INDEX_SPAN);
        fresh_shadow = '0;
        for (int i = 0; i < HFL_INDEX_SPAN; i++)
        begin
            mark_shadow[i] = 1'b0;
            link_shadow[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset limit: double frees, extremes of the index, unused kind, LIFO reuse.
        push_req(KIND_CHECK, 0);
        push_req(KIND_FREE, 0);
        push_req(KIND_ALLOC, 255);
        push_req(KIND_ALLOC, 0);
        push_req(KIND_CHECK, 0);
        push_req(KIND_CHECK, 255);
        push_req(KIND_FREE, 255);
        push_req(KIND_FREE, 1);
        push_req(KIND_FREE, 1);
        push_req(KIND_ALLOC, 0);
        push_req(KIND_UNUSED, 255);
        push_req(KIND_UNUSED, 0);
        push_req(KIND_FREE, 0);
        push_req(KIND_FREE, 1);
        push_req(KIND_ALLOC, 0);
        push_req(KIND_ALLOC, 0);
        push_req(KIND_ALLOC, 0);

        // A zero limit reports every allocate from an empty free list as full.
        settle();
        write_max_handles(0);
        push_req(KIND_ALLOC, 0);
        push_req(KIND_CHECK, 0);
        push_req(KIND_FREE, 0);

        // An entry freed under a high limit is still popped after the limit is lowered.
        settle();
        write_max_handles(HFL_INDEX_SPAN);
        push_req(KIND_FREE, 2);
        settle();
        write_max_handles(1);
        push_req(KIND_ALLOC, 0);
        push_req(KIND_CHECK, 2);
        push_req(KIND_FREE, 2);
        push_req(KIND_ALLOC, 0);
        push_req(KIND_FREE, 0);
        push_req(KIND_ALLOC, 0);

        run_phase(1, 0, 0, 60, 1'b0, 1'b0);
        run_phase(8, 87, 0, 150, 1'b0, 1'b0);
        run_phase(16, 0, 87, 150, 1'b0, 1'b0);
        run_phase(5, 36, 36, 150, 1'b0, 1'b0);
        run_phase(64, 36, 36, 150, 1'b0, 1'b0);
        run_phase(0, 0, 0, 40, 1'b0, 1'b0);
        run_phase($urandom_range(1, 300), 0, 87, 150, 1'b0, 1'b0);
        run_phase(511, 0, 0, 300, 1'b1, 1'b1);
        run_phase(HFL_INDEX_SPAN, 36, 36, 150, 1'b0, 1'b0);
        run_phase(HFL_INDEX_SPAN, 0, 0, 100, 1'b0, 1'b0);

        settle();
        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d result items never arrived", expected_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
